>>> design/erff_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions of the Ethernet receive frame filter.
package erff_pkg;

   localparam int DEFAULT_LENGTH_BITS = 16;
   localparam int HEADER_BYTES        = 14;
   localparam int FCS_BYTES           = 4;
   localparam int MIN_FRAME_BYTES     = HEADER_BYTES + FCS_BYTES;
   localparam int ADDR_BYTES          = 6;
   localparam int TYPE_HI_POS         = 12;
   localparam int TYPE_LO_POS         = 13;
   localparam int FRAME_LEN_BITS      = 16;
   localparam int MAC_BITS            = 48;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;
   localparam logic [7:0]  BYTE_ONES    = 8'hFF;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETYPE_RARP = 16'h8035;
   localparam logic [15:0] ETYPE_SNMP = 16'h814C;
   localparam logic [15:0] ETYPE_IPX  = 16'h8137;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
   localparam logic [15:0] ETYPE_PPP  = 16'h880B;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT      = 2'd0,
      VERDICT_ADDR_REJECT = 2'd1,
      VERDICT_CRC_ERROR   = 2'd2,
      VERDICT_RUNT        = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      CLASS_OTHER = 3'd0,
      CLASS_IPV4  = 3'd1,
      CLASS_ARP   = 3'd2,
      CLASS_RARP  = 3'd3,
      CLASS_SNMP  = 3'd4,
      CLASS_IPX   = 3'd5,
      CLASS_IPV6  = 3'd6,
      CLASS_PPP   = 3'd7
   } class_type;

   typedef struct packed {
      logic [7:0]                data;
      logic                      last;
      logic                      addr_en;
      logic [2:0]                addr_idx;
      logic                      type_hi;
      logic                      type_lo;
      logic                      shift_en;
      logic                      crc_en;
      logic [FRAME_LEN_BITS-1:0] length;
   } qentry_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic class_type classify(input logic [15:0] t);
      class_type c;
      unique case (t)
         ETYPE_IPV4: c = CLASS_IPV4;
         ETYPE_ARP:  c = CLASS_ARP;
         ETYPE_RARP: c = CLASS_RARP;
         ETYPE_SNMP: c = CLASS_SNMP;
         ETYPE_IPX:  c = CLASS_IPX;
         ETYPE_IPV6: c = CLASS_IPV6;
         ETYPE_PPP:  c = CLASS_PPP;
         default:    c = CLASS_OTHER;
      endcase
      return c;
   endfunction

endpackage

>>> design/ethernet_rx_frame_filter.sv
`timescale 1ns / 1ps
// Top level of the Ethernet receive frame filter.
// Throughput: one byte per cycle while the queue is not full and no stalled result holds
//   back a last byte; the front end counts bytes and the back end folds one byte a cycle
//   into the CRC, so frames stream back to back. The last byte of a frame passes through
//   the byte queue and then the result register before its verdict is valid.
// Reset: synchronous, active high; clears the queue, the frame state and the result valid,
//   and sets the station address to zero. No clearing pass is needed.
module ethernet_rx_frame_filter import erff_pkg::*; #(
   parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [MAC_BITS-1:0]       csr_station_mac,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_end_of_frame,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_verdict,
   output logic                      rsp_is_broadcast,
   output logic                      rsp_is_station_match,
   output logic [15:0]               rsp_ether_type,
   output logic [2:0]                rsp_upper_class,
   output logic [FRAME_LEN_BITS-1:0] rsp_frame_length
);

   logic [MAC_BITS-1:0] station_mac_ff;
   logic [MAC_BITS-1:0] station_mac_in;
   logic                push;
   logic                queue_full;
   logic                q_valid;
   logic                q_pop;
   qentry_type          push_entry;
   qentry_type          q_entry;

   assign csr_ready      = 1'b1;
   assign station_mac_in = (csr_valid && csr_ready) ? csr_station_mac : station_mac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_mac_ff <= '0;
      end else begin
         station_mac_ff <= station_mac_in;
      end
   end

   erff_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .queue_full       (queue_full),
      .req_stall        (req_stall),
      .push             (push),
      .entry            (push_entry)
   );

   erff_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .full       (queue_full),
      .out_valid  (q_valid),
      .out_entry  (q_entry)
   );

   erff_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_entry              (q_entry),
      .station_mac          (station_mac_ff),
      .rsp_stall            (rsp_stall),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_verdict          (rsp_verdict),
      .rsp_is_broadcast     (rsp_is_broadcast),
      .rsp_is_station_match (rsp_is_station_match),
      .rsp_ether_type       (rsp_ether_type),
      .rsp_upper_class      (rsp_upper_class),
      .rsp_frame_length     (rsp_frame_length)
   );

endmodule

>>> design/erff_front.sv
`timescale 1ns / 1ps
// Front end: accepts frame bytes, tracks position and tags each byte for the back end.
module erff_front import erff_pkg::*; #(
   parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_frame,
   input  logic       queue_full,
   output logic       req_stall,
   output logic       push,
   output qentry_type entry
);

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

   logic [LENGTH_BITS-1:0] count_ff;
   logic [LENGTH_BITS-1:0] count_in;
   logic [LENGTH_BITS-1:0] length;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign length    = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 1'b1;

   always_comb begin
      entry.data     = req_data_byte;
      entry.last     = req_end_of_frame;
      entry.addr_en  = count_ff < LENGTH_BITS'(ADDR_BYTES);
      entry.addr_idx = count_ff[2:0];
      entry.type_hi  = count_ff == LENGTH_BITS'(TYPE_HI_POS);
      entry.type_lo  = count_ff == LENGTH_BITS'(TYPE_LO_POS);
      entry.shift_en = count_ff >= LENGTH_BITS'(HEADER_BYTES);
      entry.crc_en   = count_ff >= LENGTH_BITS'(MIN_FRAME_BYTES);
      entry.length   = FRAME_LEN_BITS'(length);
   end

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = req_end_of_frame ? '0 : length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> design/erff_queue.sv
`timescale 1ns / 1ps
// Short queue of tagged bytes between the front and back ends.
module erff_queue import erff_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_entry,
   input  logic       pop,
   output logic       full,
   output logic       out_valid,
   output qentry_type out_entry
);

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   qentry_type             slots_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff;
   logic [PTR_BITS-1:0]    wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff;
   logic [PTR_BITS-1:0]    rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;
   logic                   do_pop;

   assign full      = count_ff == COUNT_BITS'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_entry = slots_ff[rd_ptr_ff];
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/erff_back.sv
`timescale 1ns / 1ps
// Back end: address match, ethertype capture, CRC check and the per-frame verdict register.
module erff_back import erff_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  qentry_type                q_entry,
   input  logic [MAC_BITS-1:0]       station_mac,
   input  logic                      rsp_stall,
   output logic                      q_pop,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_verdict,
   output logic                      rsp_is_broadcast,
   output logic                      rsp_is_station_match,
   output logic [15:0]               rsp_ether_type,
   output logic [2:0]                rsp_upper_class,
   output logic [FRAME_LEN_BITS-1:0] rsp_frame_length
);

   logic [31:0]               crc_ff;
   logic [31:0]               crc_in;
   logic [7:0]                tail_ff [FCS_BYTES];
   logic [7:0]                tail_in [FCS_BYTES];
   logic                      bcast_ff;
   logic                      bcast_in;
   logic                      station_ff;
   logic                      station_in;
   logic [15:0]               etype_ff;
   logic [15:0]               etype_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   verdict_type               verdict_ff;
   verdict_type               verdict_in;
   logic                      res_bcast_ff;
   logic                      res_bcast_in;
   logic                      res_station_ff;
   logic                      res_station_in;
   logic [15:0]               res_etype_ff;
   logic [2:0]                res_class_ff;
   logic [FRAME_LEN_BITS-1:0] res_length_ff;
   logic [7:0]                own_byte;
   logic [31:0]               fcs;
   logic                      load;
   logic                      long_enough;

   assign q_pop = q_valid && (!q_entry.last || !rsp_valid_ff || !rsp_stall);
   assign load  = q_pop && q_entry.last;

   always_comb begin
      case (q_entry.addr_idx)
         3'd0:    own_byte = station_mac[47:40];
         3'd1:    own_byte = station_mac[39:32];
         3'd2:    own_byte = station_mac[31:24];
         3'd3:    own_byte = station_mac[23:16];
         3'd4:    own_byte = station_mac[15:8];
         default: own_byte = station_mac[7:0];
      endcase
   end

   always_comb begin
      crc_in     = crc_ff;
      tail_in    = tail_ff;
      bcast_in   = bcast_ff;
      station_in = station_ff;
      etype_in   = etype_ff;
      if (q_entry.addr_en) begin
         bcast_in   = bcast_ff && (q_entry.data == BYTE_ONES);
         station_in = station_ff && (q_entry.data == own_byte);
      end
      if (q_entry.type_hi) begin
         etype_in[15:8] = q_entry.data;
      end
      if (q_entry.type_lo) begin
         etype_in[7:0] = q_entry.data;
      end
      if (q_entry.crc_en) begin
         crc_in = crc_byte(crc_ff, tail_ff[0]);
      end
      if (q_entry.shift_en) begin
         for (int i = 0; i < FCS_BYTES - 1; i++) begin
            tail_in[i] = tail_ff[i+1];
         end
         tail_in[FCS_BYTES-1] = q_entry.data;
      end
   end

   always_comb begin
      fcs            = {tail_in[3], tail_in[2], tail_in[1], tail_in[0]};
      long_enough    = q_entry.length >= FRAME_LEN_BITS'(ADDR_BYTES);
      res_bcast_in   = long_enough && bcast_in;
      res_station_in = long_enough && station_in;
      if (q_entry.length < FRAME_LEN_BITS'(MIN_FRAME_BYTES)) begin
         verdict_in = VERDICT_RUNT;
      end else if (!res_bcast_in && !res_station_in) begin
         verdict_in = VERDICT_ADDR_REJECT;
      end else if ((crc_in ^ CRC_ALL_ONES) != fcs) begin
         verdict_in = VERDICT_CRC_ERROR;
      end else begin
         verdict_in = VERDICT_ACCEPT;
      end
      rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset || load) begin
         crc_ff     <= CRC_ALL_ONES;
         bcast_ff   <= 1'b1;
         station_ff <= 1'b1;
         etype_ff   <= '0;
         for (int i = 0; i < FCS_BYTES; i++) begin
            tail_ff[i] <= '0;
         end
      end else if (q_pop) begin
         crc_ff     <= crc_in;
         bcast_ff   <= bcast_in;
         station_ff <= station_in;
         etype_ff   <= etype_in;
         tail_ff    <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff     <= verdict_in;
         res_bcast_ff   <= res_bcast_in;
         res_station_ff <= res_station_in;
         res_etype_ff   <= etype_in;
         res_class_ff   <= classify(etype_in);
         res_length_ff  <= q_entry.length;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_verdict          = verdict_ff;
   assign rsp_is_broadcast     = res_bcast_ff;
   assign rsp_is_station_match = res_station_ff;
   assign rsp_ether_type       = res_etype_ff;
   assign rsp_upper_class      = res_class_ff;
   assign rsp_frame_length     = res_length_ff;

endmodule

>>> design/erff_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the Ethernet receive frame filter and its bind.
module erff_checker import erff_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [1:0]                rsp_verdict,
   input logic                      rsp_is_broadcast,
   input logic                      rsp_is_station_match,
   input logic [15:0]               rsp_ether_type,
   input logic [2:0]                rsp_upper_class,
   input logic [FRAME_LEN_BITS-1:0] rsp_frame_length
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict) &&
         $stable(rsp_ether_type) && $stable(rsp_frame_length))
      else $error("result transaction changed while stalled");

   a_runt_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict != VERDICT_RUNT) |->
         rsp_frame_length >= FRAME_LEN_BITS'(MIN_FRAME_BYTES))
      else $error("short frame not flagged as runt");

   a_accept_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == VERDICT_ACCEPT) |->
         rsp_is_broadcast || rsp_is_station_match)
      else $error("frame accepted without address match");

   a_short_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_length < FRAME_LEN_BITS'(ADDR_BYTES)) |->
         !rsp_is_broadcast && !rsp_is_station_match)
      else $error("address flag on frame without full destination");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ethernet_rx_frame_filter erff_checker u_checker (.*);
